// ===== hw/rtl/wvot_pkg.sv =====
// shared constants and types for the windowed vwap order trigger
// no dependencies
package wvot_pkg;
  localparam int unsigned WindowDepth = 1024;
  localparam int unsigned IdxW = $clog2(WindowDepth);
  localparam int unsigned CntW = IdxW + 1;
  localparam logic [29:0] NsPerSecond = 30'd1000000000;

  typedef enum logic [2:0] {
    REG_SYMBOL  = 3'd0,
    REG_SIDE    = 3'd1,
    REG_MAX_QTY = 3'd2,
    REG_TIMEOUT = 3'd3,
    REG_WINDOW  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic        cmd;
    logic [63:0] now_time;
    logic [63:0] event_time;
    logic [63:0] symbol_code;
    logic [30:0] trade_price;
    logic [15:0] trade_qty;
    logic [30:0] bid_price;
    logic [15:0] bid_qty;
    logic [30:0] ask_price;
    logic [15:0] ask_qty;
  } mkt_item_t;

  typedef struct packed {
    logic        order_valid;
    logic [63:0] order_time;
    logic [30:0] order_price;
    logic [15:0] order_qty;
    logic [37:0] current_vwap;
    logic        running;
    logic        window_full;
  } order_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [63:0] data;
  } cfg_item_t;
endpackage

// ===== hw/rtl/wvot_if.sv =====
// valid/ready channel interfaces for the market, order and config items
// depends on wvot_pkg
interface wvot_mkt_if import wvot_pkg::*; ();
  logic      valid;
  logic      ready;
  mkt_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wvot_ord_if import wvot_pkg::*; ();
  logic        valid;
  logic        ready;
  order_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wvot_cfg_if import wvot_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/windowed_vwap_order_trigger_top.sv =====
// Sliding-window VWAP order trigger.
// Channels: mkt_i (trades and quotes in), ord_o (one result item per input
// item), cfg_i (register writes: symbol, side, max qty, timeout, window).
// Items are taken one at a time; mkt_i.ready is low from acceptance until the
// result item has been taken downstream.
// A matching quote goes from decode through shared multiplier steps for
// side price*100 and timeout*1e9 and a 64-bit compare to the result state.
// A non-matching item skips the multiplier steps.
// A trade runs one multiply for qty*100, one for price times that and the
// window limit multiply, then per expired entry one ring read, two
// multiplies and the window limit multiply again, and then a restoring
// divider that retires one quotient bit per cycle.
// Every multiply runs on one shared 32x32 multiplier with a registered
// product; the ring has one write port and one read port with registered read data.
// Reset clears all counters, sums, vwap, run mode and registers; the ring
// holds no valid bits, only entries counted by count_q are read.
// When ord_o is stalled the result stays held and no new item is taken.
module windowed_vwap_order_trigger_top import wvot_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  wvot_mkt_if.sink   mkt_i,
  wvot_ord_if.source ord_o,
  wvot_cfg_if.sink   cfg_i
);
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_QMUL, S_QTMUL, S_QDEC, S_TMUL1, S_TMUL2, S_TADD,
    S_PMUL, S_XREAD, S_XCHK, S_XMUL, S_XSUB, S_DIV, S_OUT
  } state_e;

  state_e state_q;
  mkt_item_t item_q;
  order_item_t res_q;

  logic [63:0] sym_q;
  logic        side_q;
  logic [15:0] maxq_q, tmo_q, win_q;

  logic [63:0] times_mem [WindowDepth];
  logic [46:0] pq_mem [WindowDepth];
  logic [63:0] rd_time_q;
  logic [46:0] rd_pq_q;

  logic [IdxW-1:0] oldest_q;
  logic [CntW-1:0] count_q;
  logic [63:0] spent_q;
  logic [25:0] qsum_q;
  logic [37:0] vwap_q;
  logic        run_q;
  logic [63:0] last_q;
  logic [63:0] cutoff_q;
  logic        full_q;

  // shared multiplier
  logic [31:0] ma, mb;
  logic [63:0] prod_q;
  logic [63:0] tmp_q;

  // divider
  logic [63:0] dnum_q, dquo_q;
  logic [25:0] drem_q;
  logic [5:0]  dcnt_q;
  logic [26:0] dtrial;

  logic matched;
  assign matched = (item_q.symbol_code == sym_q);

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      S_DECODE: begin ma = {1'b0, side_q ? item_q.bid_price : item_q.ask_price}; mb = 32'd100; end
      S_QMUL:   begin ma = {16'd0, tmo_q}; mb = {2'd0, NsPerSecond}; end
      S_TMUL1:  begin ma = {16'd0, item_q.trade_qty}; mb = 32'd100; end
      S_TMUL2:  begin ma = {1'b0, item_q.trade_price}; mb = prod_q[31:0]; end
      S_TADD, S_XSUB: begin ma = {16'd0, win_q}; mb = {2'd0, NsPerSecond}; end
      S_XCHK:   begin ma = {16'd0, rd_pq_q[46:31]}; mb = 32'd100; end
      S_XMUL:   begin ma = {1'b0, rd_pq_q[30:0]}; mb = prod_q[31:0]; end
      default: ;
    endcase
  end

  assign dtrial = {drem_q, dnum_q[63]} - {1'b0, qsum_q};
  logic [IdxW-1:0] slot;
  assign slot = oldest_q + count_q[IdxW-1:0];

  assign mkt_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign ord_o.valid = (state_q == S_OUT);
  assign ord_o.data  = res_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_TADD && matched && count_q < CntW'(WindowDepth)) begin
      times_mem[slot] <= item_q.event_time;
      pq_mem[slot]    <= {item_q.trade_qty, item_q.trade_price};
    end
    rd_time_q <= times_mem[oldest_q];
    rd_pq_q   <= pq_mem[oldest_q];
    prod_q    <= ma * mb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sym_q <= '0; side_q <= 1'b0; maxq_q <= '0; tmo_q <= '0; win_q <= '0;
      oldest_q <= '0; count_q <= '0; spent_q <= '0; qsum_q <= '0;
      vwap_q <= '0; run_q <= 1'b0; last_q <= '0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.data.index)
          REG_SYMBOL:  sym_q  <= cfg_i.data.data;
          REG_SIDE:    side_q <= cfg_i.data.data[0];
          REG_MAX_QTY: maxq_q <= cfg_i.data.data[15:0];
          REG_TIMEOUT: tmo_q  <= cfg_i.data.data[15:0];
          REG_WINDOW:  win_q  <= cfg_i.data.data[15:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: if (mkt_i.valid) begin
          item_q  <= mkt_i.data;
          state_q <= S_DECODE;
        end
        S_DECODE: begin
          res_q <= '0;
          full_q <= 1'b0;
          if (!matched) state_q <= S_QDEC;
          else if (item_q.cmd) state_q <= S_QMUL;
          else state_q <= S_TMUL1;
        end
        S_QMUL: begin
          tmp_q <= prod_q; // side price * 100
          state_q <= S_QTMUL;
        end
        S_QTMUL: begin
          // prod_q holds timeout limit; test now > last + limit exactly
          if (run_q && (item_q.now_time > last_q) &&
              ((item_q.now_time - last_q) > prod_q) &&
              (side_q ? (tmp_q >= {26'd0, vwap_q}) : (tmp_q <= {26'd0, vwap_q}))) begin
            res_q.order_valid <= 1'b1;
            res_q.order_time  <= item_q.event_time;
            res_q.order_price <= side_q ? item_q.bid_price : item_q.ask_price;
            if (side_q) res_q.order_qty <= (maxq_q < item_q.bid_qty) ? maxq_q : item_q.bid_qty;
            else res_q.order_qty <= (maxq_q < item_q.ask_qty) ? maxq_q : item_q.ask_qty;
            last_q <= item_q.event_time;
          end
          state_q <= S_QDEC;
        end
        S_QDEC: begin
          if (qsum_q != '0 && !item_q.cmd && matched) begin
            vwap_q             <= dquo_q[37:0];
            res_q.current_vwap <= dquo_q[37:0];
          end else begin
            res_q.current_vwap <= vwap_q;
          end
          res_q.running      <= run_q;
          res_q.window_full  <= full_q;
          state_q <= S_OUT;
        end
        S_TMUL1: state_q <= S_TMUL2;
        S_TMUL2: state_q <= S_PMUL;
        S_PMUL: begin
          tmp_q   <= prod_q; // price*qty*100
          state_q <= S_TADD;
        end
        S_TADD: begin
          if (count_q < CntW'(WindowDepth)) begin
            spent_q <= spent_q + tmp_q;
            qsum_q  <= qsum_q + 26'(item_q.trade_qty);
            count_q <= count_q + 1'b1;
          end else begin
            full_q <= 1'b1;
          end
          state_q <= S_XREAD;
        end
        S_XREAD: begin
          // prod_q is the window length in ns, at most 46 bits
          cutoff_q <= (item_q.now_time > prod_q) ? item_q.now_time - prod_q : 64'd0;
          state_q <= S_XCHK;
        end
        S_XCHK: begin
          if (count_q != '0 && rd_time_q < cutoff_q) state_q <= S_XMUL;
          else begin
            dnum_q <= spent_q; dquo_q <= '0; drem_q <= '0; dcnt_q <= '0;
            state_q <= S_DIV;
          end
        end
        S_XMUL: state_q <= S_XSUB;
        S_XSUB: begin
          spent_q  <= spent_q - prod_q;
          qsum_q   <= qsum_q - 26'(rd_pq_q[46:31]);
          oldest_q <= oldest_q + 1'b1;
          count_q  <= count_q - 1'b1;
          run_q    <= 1'b1;
          state_q  <= S_XREAD;
        end
        S_DIV: begin
          if (!dtrial[26]) begin
            drem_q <= dtrial[25:0];
            dquo_q <= {dquo_q[62:0], 1'b1};
          end else begin
            drem_q <= {drem_q[24:0], dnum_q[63]};
            dquo_q <= {dquo_q[62:0], 1'b0};
          end
          dnum_q <= {dnum_q[62:0], 1'b0};
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == 6'd63) state_q <= S_QDEC;
        end
        S_OUT: if (ord_o.ready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // xread lets the registered ring read of the new oldest entry land before xchk
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(WindowDepth)) else $error("trade count over depth");
  a_run_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |=> run_q) else $error("run mode left");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ord_o.valid && !ord_o.ready |=> ord_o.valid && $stable(res_q))
    else $error("result dropped");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ord_o.valid |-> !mkt_i.ready) else $error("accept while result pending");
endmodule

// ===== bench/windowed_vwap_order_trigger_top_tb.sv =====
// testbench for the windowed vwap order trigger: a directed table, then random phases
// under several register settings, every result checked against a vwap predictor or a fixed expected item
// depends on wvot_pkg, wvot_if and windowed_vwap_order_trigger_top
`timescale 1ns / 100ps

module windowed_vwap_order_trigger_top_tb;
  import wvot_pkg::*;

  localparam logic        CMD_TRADE = 1'b0;
  localparam logic        CMD_QUOTE = 1'b1;
  localparam logic        SIDE_BUY  = 1'b0;
  localparam logic        SIDE_SELL = 1'b1;
  localparam logic [63:0] NS        = 64'd1_000_000_000;
  localparam logic [63:0] SYM_A     = 64'h4142_4344_3132_3334;
  localparam logic [63:0] SYM_B     = 64'h5859_5a20_2020_2020;
  localparam int          N_ROWS    = 14;

  typedef struct {
    mkt_item_t   item;
    bit          typed;
    order_item_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  wvot_mkt_if mkt ();
  wvot_ord_if ord ();
  wvot_cfg_if cfg ();

  windowed_vwap_order_trigger_top dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .mkt_i (mkt.sink),
    .ord_o (ord.source),
    .cfg_i (cfg.sink)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [63:0] ring_time [WindowDepth];
  logic [30:0] ring_price[WindowDepth];
  logic [15:0] ring_qty  [WindowDepth];
  int unsigned oldest, count;
  logic [63:0] spent, qty_total, vwap_st, last_order;
  logic        run_st;
  logic [63:0] cur_symbol;
  logic        cur_side;
  logic [15:0] cur_max_qty, cur_timeout, cur_window;

  order_item_t pending_orders[$];
  int          errors = 0;
  bit          gaps_on = 1'b1;
  bit          hold_req = 1'b0;
  logic [63:0] mkt_clock;
  row_t        rows[N_ROWS];

  function automatic order_item_t vwap_predict(mkt_item_t it);
    order_item_t r;
    logic [63:0] cutoff, period, limit, p, q;
    int unsigned slot;
    bit good;
    r = '0;
    if (it.symbol_code == cur_symbol) begin
      if (it.cmd == CMD_TRADE) begin
        if (count >= WindowDepth) begin
          r.window_full = 1'b1;
        end else begin
          slot = (oldest + count) % WindowDepth;
          ring_time[slot]  = it.event_time;
          ring_price[slot] = it.trade_price;
          ring_qty[slot]   = it.trade_qty;
          spent     += 64'(it.trade_price) * 64'(it.trade_qty) * 64'd100;
          qty_total += 64'(it.trade_qty);
          count++;
        end
        period = 64'(cur_window) * NS;
        cutoff = (it.now_time > period) ? it.now_time - period : 64'd0;
        while (count > 0 && ring_time[oldest] < cutoff) begin
          spent     -= 64'(ring_price[oldest]) * 64'(ring_qty[oldest]) * 64'd100;
          qty_total -= 64'(ring_qty[oldest]);
          oldest = (oldest + 1) % WindowDepth;
          count--;
          run_st = 1'b1;
        end
        if (qty_total != 0) vwap_st = (spent / qty_total) & 64'h3F_FFFF_FFFF;
      end else begin
        p = (cur_side == SIDE_BUY) ? 64'(it.ask_price) : 64'(it.bid_price);
        q = (cur_side == SIDE_BUY) ? 64'(it.ask_qty) : 64'(it.bid_qty);
        good = (cur_side == SIDE_BUY) ? (p * 64'd100 <= vwap_st) : (p * 64'd100 >= vwap_st);
        limit = 64'(cur_timeout) * NS;
        if (run_st && it.now_time > last_order && (it.now_time - last_order) > limit && good)
        begin
          r.order_valid = 1'b1;
          r.order_time  = it.event_time;
          r.order_price = p[30:0];
          r.order_qty   = (64'(cur_max_qty) < q) ? cur_max_qty : q[15:0];
          last_order    = it.event_time;
        end
      end
    end
    r.current_vwap = vwap_st[37:0];
    r.running      = run_st;
    return r;
  endfunction

  function automatic mkt_item_t mk(logic c, logic [63:0] now, logic [63:0] ev,
                                   logic [63:0] sym, logic [30:0] tp, logic [15:0] tq,
                                   logic [30:0] bp, logic [15:0] bq,
                                   logic [30:0] ap, logic [15:0] aq);
    mkt_item_t it;
    it.cmd = c; it.now_time = now; it.event_time = ev; it.symbol_code = sym;
    it.trade_price = tp; it.trade_qty = tq;
    it.bid_price = bp; it.bid_qty = bq; it.ask_price = ap; it.ask_qty = aq;
    return it;
  endfunction

  // mostly well-formed matching traffic, quotes around the current vwap, rest is noise
  function automatic mkt_item_t rand_item(int unsigned trade_pct);
    mkt_item_t   it;
    logic [63:0] ev;
    logic [30:0] center;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) begin
      it = mkt_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom, $urandom});
      if (it.symbol_code == cur_symbol) it.symbol_code = ~cur_symbol;
      return it;
    end
    mkt_clock += 64'($urandom_range(400_000_000));
    ev = ($urandom_range(99) < 10) ? mkt_clock - 64'($urandom_range(900_000_000)) : mkt_clock;
    center = (vwap_st == 0) ? 31'd10000 : 31'(vwap_st / 100);
    it = mk(CMD_TRADE, mkt_clock, ev, cur_symbol, 0, 0, 0, 0, 0, 0);
    if ($urandom_range(99) < trade_pct) begin
      it.trade_price = 31'd10000 + 31'($urandom_range(400)) - 31'd200;
      it.trade_qty   = 16'($urandom_range(1000));
      if (r < 12) begin
        it.trade_price = 31'($urandom >> 1);
        it.trade_qty   = 16'($urandom);
      end
    end else begin
      it.cmd       = CMD_QUOTE;
      it.bid_price = center + 31'($urandom_range(60)) - 31'd30;
      it.ask_price = center + 31'($urandom_range(60)) - 31'd30;
      it.bid_qty   = 16'($urandom);
      it.ask_qty   = 16'($urandom);
      if (r < 12) begin
        it.bid_price = 31'($urandom >> 1);
        it.ask_price = 31'($urandom >> 1);
      end
    end
    return it;
  endfunction

  task automatic send_item(mkt_item_t it, bit typed, order_item_t want);
    order_item_t predicted;
    while (gaps_on && $urandom_range(99) < 7) begin
      mkt.valid <= 1'b0;
      @(posedge clk);
    end
    mkt.valid <= 1'b1;
    mkt.data  <= it;
    do @(posedge clk); while (!mkt.ready);
    predicted = vwap_predict(it);
    pending_orders.push_back(typed ? want : predicted);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [63:0] value);
    cfg.valid      <= 1'b1;
    cfg.data.index <= idx;
    cfg.data.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_SYMBOL:  cur_symbol  = value;
      REG_SIDE:    cur_side    = value[0];
      REG_MAX_QTY: cur_max_qty = value[15:0];
      REG_TIMEOUT: cur_timeout = value[15:0];
      REG_WINDOW:  cur_window  = value[15:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    mkt.valid <= 1'b0;
    while (pending_orders.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(logic [63:0] sym, logic side, logic [15:0] mq,
                           logic [15:0] to, logic [15:0] win);
    settle();
    write_reg(REG_SYMBOL, sym);
    write_reg(REG_SIDE, 64'(side));
    write_reg(REG_MAX_QTY, 64'(mq));
    write_reg(REG_TIMEOUT, 64'(to));
    write_reg(REG_WINDOW, 64'(win));
    cfg.valid <= 1'b0;
  endtask

  task automatic run_random(int unsigned n, int unsigned trade_pct);
    repeat (n) send_item(rand_item(trade_pct), 1'b0, '0);
  endtask

  // receiver: random stalls, plus one long hold on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    ord.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        ord.ready <= 1'b0;
        hold_left--;
      end else begin
        ord.ready <= !(gaps_on && $urandom_range(99) < 7);
      end
    end
  end

  always @(posedge clk) begin
    order_item_t exp_o;
    if (ord.valid && ord.ready) begin
      if (pending_orders.size() == 0) begin
        $error("order item with nothing expected");
        errors++;
      end else begin
        exp_o = pending_orders.pop_front();
        if (ord.data.order_valid !== exp_o.order_valid) begin
          $error("order_valid: expected %0d, got %0d", exp_o.order_valid, ord.data.order_valid);
          errors++;
        end
        if (ord.data.order_time !== exp_o.order_time) begin
          $error("order_time: expected %0d, got %0d", exp_o.order_time, ord.data.order_time);
          errors++;
        end
        if (ord.data.order_price !== exp_o.order_price) begin
          $error("order_price: expected %0d, got %0d", exp_o.order_price, ord.data.order_price);
          errors++;
        end
        if (ord.data.order_qty !== exp_o.order_qty) begin
          $error("order_qty: expected %0d, got %0d", exp_o.order_qty, ord.data.order_qty);
          errors++;
        end
        if (ord.data.current_vwap !== exp_o.current_vwap) begin
          $error("current_vwap: expected %0d, got %0d", exp_o.current_vwap,
                 ord.data.current_vwap);
          errors++;
        end
        if (ord.data.running !== exp_o.running) begin
          $error("running: expected %0d, got %0d", exp_o.running, ord.data.running);
          errors++;
        end
        if (ord.data.window_full !== exp_o.window_full) begin
          $error("window_full: expected %0d, got %0d", exp_o.window_full, ord.data.window_full);
          errors++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [63:0] hi;
    hi = '1;
    mkt.valid <= 1'b0;
    mkt.data  <= '0;
    cfg.valid <= 1'b0;
    cfg.data  <= '0;
    oldest = 0; count = 0; spent = 0; qty_total = 0; vwap_st = 0;
    run_st = 1'b0; last_order = 0;
    cur_symbol = 0; cur_side = SIDE_BUY; cur_max_qty = 0; cur_timeout = 0; cur_window = 0;
    mkt_clock = 64'd20 * NS;

    // directed rows, window 1s, buy side, cap 100, no timeout
    rows[0]  = '{mk(CMD_QUOTE, NS, NS, ~SYM_A, 0, 0, 5, 5, 5, 5), 1'b1, '0};
    rows[1]  = '{mk(CMD_QUOTE, NS, NS, SYM_A, 0, 0, 5, 5, 5, 5), 1'b1, '0};
    rows[2]  = '{mk(CMD_TRADE, NS, NS, SYM_A, 10000, 10, 0, 0, 0, 0), 1'b0, '0};
    rows[3]  = '{mk(CMD_TRADE, 64'd1_100_000_000, 64'd1_100_000_000, SYM_A, 31'h7FFF_FFFF,
                    16'hFFFF, 0, 0, 0, 0), 1'b0, '0};
    rows[4]  = '{mk(CMD_TRADE, 64'd1_150_000_000, 64'd1_150_000_000, SYM_A, 0, 0, 0, 0, 0, 0),
                 1'b0, '0};
    rows[5]  = '{mk(CMD_TRADE, 64'd1_200_000_000, 64'd1_200_000_000, SYM_A, 0, 16'hFFFF,
                    0, 0, 0, 0), 1'b0, '0};
    // first expiry enters run mode
    rows[6]  = '{mk(CMD_TRADE, 5 * NS, 5 * NS, SYM_A, 9000, 50, 0, 0, 0, 0), 1'b0, '0};
    rows[7]  = '{mk(CMD_QUOTE, 5 * NS, 5 * NS, SYM_A, 0, 0, 9100, 7, 80, 500), 1'b0, '0};
    // same time as the last order: timeout not yet elapsed
    rows[8]  = '{mk(CMD_QUOTE, 5 * NS, 5 * NS, SYM_A, 0, 0, 9100, 7, 80, 500), 1'b0, '0};
    rows[9]  = '{mk(CMD_QUOTE, 6 * NS, 6 * NS, SYM_A, 0, 0, 31'h7FFF_FFFF, 16'hFFFF,
                    31'h7FFF_FFFF, 16'hFFFF), 1'b0, '0};
    rows[10] = '{mk(CMD_QUOTE, 7 * NS, 7 * NS, SYM_A, 0, 0, 0, 0, 0, 0), 1'b0, '0};
    rows[11] = '{mk(CMD_TRADE, hi, hi, ~SYM_A, 31'h7FFF_FFFF, 16'hFFFF, 31'h7FFF_FFFF,
                    16'hFFFF, 31'h7FFF_FFFF, 16'hFFFF), 1'b0, '0};
    // everything expires at once: zero total quantity keeps the vwap
    rows[12] = '{mk(CMD_TRADE, hi, 8 * NS, SYM_A, 777, 3, 0, 0, 0, 0), 1'b0, '0};
    // a trade already older than the window is added and expires at once
    rows[13] = '{mk(CMD_TRADE, 64'd10_500_000_000, 64'd7 * NS, SYM_A, 500, 4, 0, 0, 0, 0),
                 1'b0, '0};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    configure(SYM_A, SIDE_BUY, 16'd100, 16'd0, 16'd1);
    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].want);

    configure(SYM_A, SIDE_BUY, 16'd100, 16'd0, 16'd1);
    run_random(25, 60);
    hold_req = 1'b1;
    run_random(15, 60);

    configure(SYM_A, SIDE_SELL, 16'hFFFF, 16'd1, 16'd2);
    run_random(25, 50);

    // no idling for a while
    gaps_on = 1'b0;
    configure(SYM_B, SIDE_BUY, 16'd0, 16'd0, 16'd0);
    run_random(25, 50);
    gaps_on = 1'b1;

    // fill the ring past its depth, then drain it with a zero window
    configure(SYM_B, SIDE_SELL, 16'd37, 16'd0, 16'hFFFF);
    repeat (WindowDepth + 8) begin
      mkt_clock += 64'd1000;
      send_item(mk(CMD_TRADE, mkt_clock, mkt_clock, SYM_B, 31'd10000 + 31'($urandom_range(50)),
                   16'($urandom_range(1, 900)), 0, 0, 0, 0), 1'b0, '0);
    end
    configure(SYM_B, SIDE_SELL, 16'd37, 16'd0, 16'd0);
    mkt_clock += NS;
    run_random(25, 50);

    configure(64'($urandom) << 32 | 64'($urandom), SIDE_BUY, 16'($urandom),
              16'($urandom_range(3)), 16'($urandom_range(1, 3)));
    run_random(25, 50);

    configure(SYM_A, SIDE_SELL, 16'd500, 16'hFFFF, 16'd1);
    run_random(25, 50);

    mkt.valid <= 1'b0;
    while (pending_orders.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
